// ----- sv/tbdvs_pkg.sv -----
// ----------------------------------------------------------------------------
// tbdvs_pkg
// Shared types, register indexes and constants of the twin bed dryer valve
// sequencer.
// ----------------------------------------------------------------------------
package tbdvs_pkg;

  localparam int unsigned TickW    = 16;
  localparam int unsigned MaskW    = 8;
  localparam int unsigned ValveW   = 7;
  localparam int unsigned CfgIdxW  = 3;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PAIR_SWITCH = 3'd0,
    REG_PAIR_WRAP   = 3'd1,
    REG_PURGE_OPEN  = 3'd2,
    REG_PURGE_CLOSE = 3'd3,
    REG_VENT_OPEN   = 3'd4,
    REG_CYCLE_END   = 3'd5
  } cfg_reg_t;

  // register reset values
  localparam logic [TickW-1:0] PAIR_SWITCH_RST = 16'd451;
  localparam logic [TickW-1:0] PAIR_WRAP_RST   = 16'd500;
  localparam logic [TickW-1:0] PURGE_OPEN_RST  = 16'd501;
  localparam logic [TickW-1:0] PURGE_CLOSE_RST = 16'd14501;
  localparam logic [TickW-1:0] VENT_OPEN_RST   = 16'd19502;
  localparam logic [TickW-1:0] CYCLE_END_RST   = 16'd19999;

  // fixed bed timer ticks of the bed open events
  localparam logic [TickW-1:0] BED_OPEN_TICK_A = 16'd3;
  localparam logic [TickW-1:0] BED_OPEN_TICK_B = 16'd6;

  // fixed pair timer ticks of the early pair events
  localparam logic [TickW-1:0] PAIR_OPEN_TICK_A  = 16'd1;
  localparam logic [TickW-1:0] PAIR_OPEN_TICK_B  = 16'd4;
  localparam logic [TickW-1:0] PAIR_CLOSE_TICK_A = 16'd2;
  localparam logic [TickW-1:0] PAIR_CLOSE_TICK_B = 16'd5;

  // command output masks
  localparam logic [MaskW-1:0] MASK_NONE   = 8'h00;
  localparam logic [MaskW-1:0] MASK_V1     = 8'h02;
  localparam logic [MaskW-1:0] MASK_V2     = 8'h04;
  localparam logic [MaskW-1:0] MASK_V3     = 8'h08;
  localparam logic [MaskW-1:0] MASK_V4     = 8'h10;
  localparam logic [MaskW-1:0] MASK_V5     = 8'h20;
  localparam logic [MaskW-1:0] MASK_V6     = 8'h40;
  localparam logic [MaskW-1:0] MASK_V7     = 8'h80;
  localparam logic [MaskW-1:0] MASK_ALL    = 8'hFE;

  // valve status bits (bit k is valve k+1)
  localparam logic [ValveW-1:0] VB_V1 = 7'h01;
  localparam logic [ValveW-1:0] VB_V2 = 7'h02;
  localparam logic [ValveW-1:0] VB_V3 = 7'h04;
  localparam logic [ValveW-1:0] VB_V4 = 7'h08;
  localparam logic [ValveW-1:0] VB_V5 = 7'h10;
  localparam logic [ValveW-1:0] VB_V6 = 7'h20;
  localparam logic [ValveW-1:0] VB_V7 = 7'h40;

  typedef struct packed {
    logic [TickW-1:0] pair_switch;
    logic [TickW-1:0] pair_wrap;
    logic [TickW-1:0] purge_open;
    logic [TickW-1:0] purge_close;
    logic [TickW-1:0] vent_open;
    logic [TickW-1:0] cycle_end;
  } tbdvs_cfg_t;

  typedef struct packed {
    logic [TickW-1:0]  bed_timer;
    logic [TickW-1:0]  pair_timer;
    logic              bed_sel;
    logic [1:0]        idle_cnt;
    logic [ValveW-1:0] valves;
  } tbdvs_state_t;

  typedef struct packed {
    logic              pair_valid;
    logic [MaskW-1:0]  pair_mask;
    logic              pair_set;
    logic              bed_valid;
    logic [MaskW-1:0]  bed_mask;
    logic              bed_set;
    logic [ValveW-1:0] valve_status;
  } tbdvs_result_t;

endpackage

// ----- sv/twin_bed_dryer_valve_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// twin_bed_dryer_valve_sequencer_unit
// Tick driven valve sequencer for a twin bed dryer with pair and bed timers.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction on in_* is one tick carrying the run flag
//   in_stack_power. Each tick yields exactly one output transaction on out_*
//   with the pair command, the bed command and the valve status after that
//   tick.
//   The result of an accepted tick is registered and shown on out_* from
//   the next cycle. Throughput is one tick per cycle while results are taken,
//   set by the single registered pass through the step logic; the output
//   register lets a tick in whenever it is empty or is drained in the same cycle.
//   When the receiver stalls, the result holds on out_* and in_ready drops
//   until it is taken; no transaction is lost.
//   Settings are to be written through cfg_we / cfg_index / cfg_data only
//   while idle; the block does not enforce this. Unknown indexes are ignored.
//   Reset loads the default settings, clears both timers, selects the first
//   bed, turns all valves off and empties the output register.
// ----------------------------------------------------------------------------
module twin_bed_dryer_valve_sequencer_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // tick channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_stack_power,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_pair_cmd_valid,
  output logic [tbdvs_pkg::MaskW-1:0]   out_pair_cmd_mask,
  output logic                          out_pair_cmd_set,
  output logic                          out_bed_cmd_valid,
  output logic [tbdvs_pkg::MaskW-1:0]   out_bed_cmd_mask,
  output logic                          out_bed_cmd_set,
  output logic [tbdvs_pkg::ValveW-1:0]  out_valve_status,
  // configuration
  input  logic                          cfg_we,
  input  logic [tbdvs_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [tbdvs_pkg::TickW-1:0]   cfg_data
);
  import tbdvs_pkg::*;

  tbdvs_cfg_t    cfg_r;
  tbdvs_state_t  state_r;
  tbdvs_state_t  state_nxt;
  tbdvs_result_t res_nxt;
  tbdvs_result_t res_r;
  logic          out_valid_r;
  logic          in_fire;

  // handshake
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pair_switch <= PAIR_SWITCH_RST;
      cfg_r.pair_wrap   <= PAIR_WRAP_RST;
      cfg_r.purge_open  <= PURGE_OPEN_RST;
      cfg_r.purge_close <= PURGE_CLOSE_RST;
      cfg_r.vent_open   <= VENT_OPEN_RST;
      cfg_r.cycle_end   <= CYCLE_END_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAIR_SWITCH: cfg_r.pair_switch <= cfg_data;
        REG_PAIR_WRAP:   cfg_r.pair_wrap   <= cfg_data;
        REG_PURGE_OPEN:  cfg_r.purge_open  <= cfg_data;
        REG_PURGE_CLOSE: cfg_r.purge_close <= cfg_data;
        REG_VENT_OPEN:   cfg_r.vent_open   <= cfg_data;
        REG_CYCLE_END:   cfg_r.cycle_end   <= cfg_data;
        default: ;
      endcase
    end
  end

  // tick logic
  tbdvs_step u_step (
    .cfg (cfg_r),
    .cur (state_r),
    .run (in_stack_power),
    .nxt (state_nxt),
    .res (res_nxt)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pair_cmd_valid = res_r.pair_valid;
  assign out_pair_cmd_mask  = res_r.pair_mask;
  assign out_pair_cmd_set   = res_r.pair_set;
  assign out_bed_cmd_valid  = res_r.bed_valid;
  assign out_bed_cmd_mask   = res_r.bed_mask;
  assign out_bed_cmd_set    = res_r.bed_set;
  assign out_valve_status   = res_r.valve_status;

  // shown valve status always matches the held valve state
  a_status_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_valve_status == state_r.valves)
    else $error("valve status differs from valve state");

  // an idle tick resets timers and bed selection
  a_idle_resets_timers: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_stack_power |=>
      state_r.bed_timer == '0 && state_r.pair_timer == '0 && !state_r.bed_sel)
    else $error("idle tick left timers running");

  // pair command only ever addresses valve 1 or valve 2
  a_pair_mask_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_pair_cmd_valid |->
      out_pair_cmd_mask == MASK_V1 || out_pair_cmd_mask == MASK_V2)
    else $error("illegal pair command mask");

  // no bed command fields without a bed command
  a_bed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_bed_cmd_valid |->
      out_bed_cmd_mask == MASK_NONE && !out_bed_cmd_set)
    else $error("bed command fields set without a command");

  // a clear-all command leaves every valve off
  a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bed_cmd_valid && out_bed_cmd_mask == MASK_ALL |->
      out_valve_status == '0)
    else $error("clear-all left a valve on");

endmodule

// ----- sv/tbdvs_step.sv -----
// ----------------------------------------------------------------------------
// tbdvs_step
// One tick of the sequencer: next timer, bed and valve state and the two
// command channels, from the current state, the run flag and the settings.
// ----------------------------------------------------------------------------
module tbdvs_step (
  input  tbdvs_pkg::tbdvs_cfg_t    cfg,
  input  tbdvs_pkg::tbdvs_state_t  cur,
  input  logic                     run,
  output tbdvs_pkg::tbdvs_state_t  nxt,
  output tbdvs_pkg::tbdvs_result_t res
);
  import tbdvs_pkg::*;

  logic [TickW-1:0]  pt;
  logic [TickW-1:0]  bt;
  logic [TickW:0]    pt_w;
  logic [TickW:0]    bt_w;
  logic [TickW:0]    sw_w;
  logic [TickW:0]    po_w;
  logic [TickW:0]    pc_w;
  logic [TickW:0]    vo_w;
  logic [TickW:0]    ce_w;
  logic [MaskW-1:0]  open_mask;
  logic [MaskW-1:0]  purge_mask;
  logic [ValveW-1:0] open_bit;
  logic [ValveW-1:0] purge_bit;
  logic [ValveW-1:0] other_bit;
  logic [ValveW-1:0] v;
  logic [1:0]        idle_inc;

  // incremented timers, and timers and compare points widened by one bit so the offset compare points never wrap
  assign pt   = cur.pair_timer + 16'd1;
  assign bt   = cur.bed_timer + 16'd1;
  assign pt_w = {1'b0, pt};
  assign bt_w = {1'b0, bt};
  assign sw_w = {1'b0, cfg.pair_switch};
  assign po_w = {1'b0, cfg.purge_open};
  assign pc_w = {1'b0, cfg.purge_close};
  assign vo_w = {1'b0, cfg.vent_open};
  assign ce_w = {1'b0, cfg.cycle_end};
  assign idle_inc = (cur.idle_cnt != 2'd3) ? cur.idle_cnt + 2'd1 : cur.idle_cnt;

  // active bed valve selection
  always_comb begin
    if (!cur.bed_sel) begin
      open_mask  = MASK_V4;
      open_bit   = VB_V4;
      purge_mask = MASK_V6;
      purge_bit  = VB_V6;
      other_bit  = VB_V5;
    end else begin
      open_mask  = MASK_V3;
      open_bit   = VB_V3;
      purge_mask = MASK_V5;
      purge_bit  = VB_V5;
      other_bit  = VB_V6;
    end
  end

  // event decode and state update
  always_comb begin
    nxt = cur;
    res = '0;
    v   = cur.valves;
    if (run) begin
      nxt.idle_cnt = 2'd0;
      // pair channel
      priority if (pt == PAIR_OPEN_TICK_A || pt == PAIR_OPEN_TICK_B) begin
        res.pair_valid = 1'b1;
        res.pair_mask  = MASK_V1;
        res.pair_set   = 1'b1;
        v = v | VB_V1;
      end else if (pt == PAIR_CLOSE_TICK_A || pt == PAIR_CLOSE_TICK_B) begin
        res.pair_valid = 1'b1;
        res.pair_mask  = MASK_V2;
        v = v & ~VB_V2;
      end else if (pt_w == sw_w || pt_w == sw_w + 17'd2) begin
        res.pair_valid = 1'b1;
        res.pair_mask  = MASK_V1;
        v = v & ~VB_V1;
      end else if (pt_w == sw_w + 17'd1 || pt_w == sw_w + 17'd3) begin
        res.pair_valid = 1'b1;
        res.pair_mask  = MASK_V2;
        res.pair_set   = 1'b1;
        v = v | VB_V2;
      end else begin
        res.pair_valid = 1'b0;
      end
      // inactive bed purge valve forced off
      v = v & ~other_bit;
      // bed channel, first matching event wins
      priority if (bt == BED_OPEN_TICK_A || bt == BED_OPEN_TICK_B) begin
        res.bed_valid = 1'b1;
        res.bed_mask  = open_mask;
        res.bed_set   = 1'b1;
        v = v | open_bit;
      end else if (bt_w == po_w || bt_w == po_w + 17'd1) begin
        res.bed_valid = 1'b1;
        res.bed_mask  = purge_mask;
        res.bed_set   = 1'b1;
        v = v | purge_bit;
      end else if (bt_w == pc_w || bt_w == pc_w + 17'd2) begin
        res.bed_valid = 1'b1;
        res.bed_mask  = purge_mask;
        v = v & ~purge_bit;
      end else if (bt_w == vo_w || bt_w == vo_w + 17'd2) begin
        res.bed_valid = 1'b1;
        res.bed_mask  = MASK_V7;
        res.bed_set   = 1'b1;
        v = v | VB_V7;
      end else if (bt_w == ce_w || bt_w == ce_w + 17'd1) begin
        res.bed_valid = 1'b1;
        res.bed_mask  = MASK_ALL;
        v = '0;
      end else begin
        res.bed_valid = 1'b0;
      end
      // timer wrap and bed alternation
      if (bt_w > ce_w + 17'd1) begin
        nxt.bed_timer = '0;
        nxt.bed_sel   = ~cur.bed_sel;
      end else begin
        nxt.bed_timer = bt;
      end
      nxt.pair_timer = (pt > cfg.pair_wrap) ? '0 : pt;
    end else begin
      nxt.bed_timer  = '0;
      nxt.pair_timer = '0;
      nxt.bed_sel    = 1'b0;
      nxt.idle_cnt   = idle_inc;
      // clear-all on the first two idle ticks
      if (idle_inc == 2'd1 || idle_inc == 2'd2) begin
        res.bed_valid = 1'b1;
        res.bed_mask  = MASK_ALL;
        v = '0;
      end
    end
    nxt.valves       = v;
    res.valve_status = v;
  end

endmodule
